FILE: sv/bblur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and helpers for the 3x3 box blur stream block.
// ---------------------------------------------------------------------------
package bblur_pkg;

    // channel and pixel widths
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;

    // arithmetic widths: 9 * 255 fits 12 bits, 2 * sum + count fits 13 bits
    localparam int SUM_W      = 12;
    localparam int NUM_W      = 13;
    localparam int CNT_W      = 4;
    localparam int DEN_W      = 5;
    localparam int STEP_W     = 3;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0] den_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // input word codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // register reset values
    localparam logic [CFG_W_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // controller to datapath commands
    typedef struct packed {
        logic rd_en;
        logic pix_load;
        logic flush;
        logic shift_en;
        logic sum_start;
        logic out_load;
        logic up;
        logic down;
        logic left;
        logic right;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } dp_status_t;

    // number of in-frame neighbours from row and column counts (1..3 each)
    function automatic cnt_t neighbour_count(input logic [1:0] rows, input logic [1:0] cols);
        cnt_t n;
        case ({rows, cols})
            4'b0101: n = 4'd1;
            4'b0110: n = 4'd2;
            4'b0111: n = 4'd3;
            4'b1001: n = 4'd2;
            4'b1010: n = 4'd4;
            4'b1011: n = 4'd6;
            4'b1101: n = 4'd3;
            4'b1110: n = 4'd6;
            4'b1111: n = 4'd9;
            default: n = 4'd1;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: sv/box_blur_3x3_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// box_blur_3x3_stream_top
// Streaming 3x3 box blur over RGB frames with edge-clipped neighbourhoods.
//
// channel  role    handshake              payload
// in       sink    in_valid / in_ready    cmd, pixel_red, pixel_green, pixel_blue
// out      source  out_valid / out_ready  blurred_red, blurred_green, blurred_blue,
//                                         frame_end
// cfg      sink    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a word that yields a result passes accept and line read, window shift,
// sum, 8 divider steps and output load; an ignored drain word is only accepted
// a word without a result passes only accept and line read and window shift
// the line memory needs no clearing pass; reset clears window and counters
// the output register lets the next word start while a result waits; the
// block stalls in its output step only if the previous result is untaken
// ---------------------------------------------------------------------------
module box_blur_3x3_stream_top
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   cmd,
    input  wire logic [7:0]             pixel_red,
    input  wire logic [7:0]             pixel_green,
    input  wire logic [7:0]             pixel_blue,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  blurred_red,
    output logic [7:0]                  blurred_green,
    output logic [7:0]                  blurred_blue,
    output logic                        frame_end,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    dp_cmd_t            dp_cmd;
    dp_status_t         dp_status;
    logic [ADDR_W-1:0]  dp_addr;

    // sequencer and frame position
    bblur_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .frame_end (frame_end),
        .dp_cmd    (dp_cmd),
        .dp_addr   (dp_addr),
        .dp_status (dp_status)
    );

    // line memory, window and arithmetic
    bblur_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (dp_cmd),
        .addr          (dp_addr),
        .pixel_red     (pixel_red),
        .pixel_green   (pixel_green),
        .pixel_blue    (pixel_blue),
        .status        (dp_status),
        .blurred_red   (blurred_red),
        .blurred_green (blurred_green),
        .blurred_blue  (blurred_blue)
    );

endmodule
`default_nettype wire

FILE: sv/bblur_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bblur_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ---------------------------------------------------------------------------
module bblur_div
    import bblur_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire num_t [2:0]      num,
    input  wire den_t            den,
    output logic                 done,
    output chan_t [2:0]          quo
);

    num_t  [2:0]        rem_reg;
    chan_t [2:0]        quo_reg;
    den_t               den_reg;
    logic [STEP_W-1:0]  bit_reg;
    logic               busy_reg;
    num_t               trial;
    logic [2:0]         fits;

    // shifted divisor and per-lane compare
    always_comb
    begin
        trial = NUM_W'(den_reg) << bit_reg;
        for (int i = 0; i < 3; i++)
        begin
            fits[i] = rem_reg[i] >= trial;
        end
    end

    assign done = busy_reg && (bit_reg == '0);
    assign quo  = quo_reg;

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            bit_reg  <= STEP_W'(CH_W - 1);
        end
        else if (busy_reg)
        begin
            if (bit_reg == '0)
                busy_reg <= 1'b0;
            else
                bit_reg <= bit_reg - STEP_W'(1);
        end
    end

    // remainders and quotients
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            quo_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (fits[i])
                begin
                    rem_reg[i]          <= rem_reg[i] - trial;
                    quo_reg[i][bit_reg] <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/bblur_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bblur_dpath
// Line memory, 3x3 window, masked sums and rounding divide per channel.
// ---------------------------------------------------------------------------
module bblur_dpath
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dp_cmd_t                       ctl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  wire chan_t                         pixel_red,
    input  wire chan_t                         pixel_green,
    input  wire chan_t                         pixel_blue,
    output dp_status_t                         status,
    output chan_t                              blurred_red,
    output chan_t                              blurred_green,
    output chan_t                              blurred_blue
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // line memory: older row in the upper half, newer row in the lower half
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [ADDR_W-1:0]  addr_reg;
    pix_t               pixel_reg;
    pix_t               win_reg [3][3];
    chan_t              red_reg;
    chan_t              green_reg;
    chan_t              blue_reg;

    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    logic [1:0]         rows;
    logic [1:0]         cols;
    cnt_t               count;
    sum_t [2:0]         sum;
    num_t [2:0]         num;
    den_t               den;
    chan_t [2:0]        quo;
    logic               div_done;

    // incoming pixel, zero while flushing
    always_ff @(posedge clk)
    begin
        if (ctl.pix_load)
        begin
            pixel_reg <= ctl.flush ? '0 : {pixel_red, pixel_green, pixel_blue};
            addr_reg  <= addr;
        end
    end

    // line memory read and write-back
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            rd_reg <= line_mem[addr];
        if (ctl.shift_en)
            line_mem[addr_reg] <= {rd_reg[PIX_W-1:0], pixel_reg};
    end

    // window shift, new column enters on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (ctl.shift_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_reg[2*PIX_W-1:PIX_W];
            win_reg[1][2] <= rd_reg[PIX_W-1:0];
            win_reg[2][2] <= pixel_reg;
        end
    end

    // masked channel sums over the in-frame neighbours
    always_comb
    begin
        row_ok = {ctl.down, 1'b1, ctl.up};
        col_ok = {ctl.right, 1'b1, ctl.left};
        sum    = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        sum[k] = sum[k] + SUM_W'(win_reg[r][c][k*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // round half up: (2 * sum + count) / (2 * count)
    always_comb
    begin
        rows  = 2'd1 + {1'b0, ctl.up} + {1'b0, ctl.down};
        cols  = 2'd1 + {1'b0, ctl.left} + {1'b0, ctl.right};
        count = neighbour_count(rows, cols);
        den   = {count, 1'b0};
        for (int k = 0; k < 3; k++)
        begin
            num[k] = {sum[k], 1'b0} + NUM_W'(count);
        end
    end

    bblur_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.sum_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (quo)
    );

    assign status.div_done = div_done;

    // output word register, lane 2 is red
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            red_reg   <= quo[2];
            green_reg <= quo[1];
            blue_reg  <= quo[0];
        end
    end

    assign blurred_red   = red_reg;
    assign blurred_green = green_reg;
    assign blurred_blue  = blue_reg;

endmodule
`default_nettype wire

FILE: sv/bblur_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bblur_ctrl
// Frame position tracking, configuration registers and the item sequencer.
// ---------------------------------------------------------------------------
module bblur_ctrl
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               frame_end,
    output dp_cmd_t                            dp_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]       dp_addr,
    input  wire dp_status_t                    dp_status
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W  = WCNT_W + HCNT_W;
    localparam int ITEM_W = TOT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_W_W-1:0]  frame_width_reg;
    logic [CFG_H_W-1:0]  frame_height_reg;
    logic [WCNT_W-1:0]   aw_reg;
    logic [HCNT_W-1:0]   ah_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [ITEM_W-1:0]   items_reg;
    logic [ADDR_W-1:0]   col_reg;
    logic [HCNT_W-1:0]   orow_reg;
    logic [ADDR_W-1:0]   ocol_reg;
    logic                has_out_reg;
    logic                last_reg;
    logic                up_reg;
    logic                down_reg;
    logic                left_reg;
    logic                right_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                frame_end_reg;

    logic [WCNT_W-1:0]   width_clamped;
    logic [HCNT_W-1:0]   height_clamped;
    logic [WCNT_W-1:0]   aw_use;
    logic [HCNT_W-1:0]   ah_use;
    logic                first;
    logic                flush;
    logic                take;
    logic                has_out;
    logic [ADDR_W:0]     col_inc;
    logic [ADDR_W:0]     ocol_inc;
    logic [HCNT_W:0]     orow_inc;
    logic                last_col;
    logic                last_row;
    logic                last;
    logic                out_load;

    // frame size saturated into the legal range
    always_comb
    begin
        if (frame_width_reg == '0)
            width_clamped = WCNT_W'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            width_clamped = WCNT_W'(MAX_WIDTH);
        else
            width_clamped = WCNT_W'(frame_width_reg);

        if (frame_height_reg == '0)
            height_clamped = HCNT_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            height_clamped = HCNT_W'(MAX_HEIGHT);
        else
            height_clamped = HCNT_W'(frame_height_reg);
    end

    // per-word decode, size taken fresh on the first word of a frame
    always_comb
    begin
        first    = items_reg == '0;
        aw_use   = first ? width_clamped : aw_reg;
        ah_use   = first ? height_clamped : ah_reg;
        flush    = !first && (items_reg >= ITEM_W'(total_reg));
        take     = (state_reg == S_IDLE) && in_valid && !(cmd == CMD_DRAIN && !flush);
        has_out  = items_reg >= (ITEM_W'(aw_use) + ITEM_W'(1));
        col_inc  = {1'b0, col_reg} + (ADDR_W + 1)'(1);
        ocol_inc = {1'b0, ocol_reg} + (ADDR_W + 1)'(1);
        orow_inc = {1'b0, orow_reg} + (HCNT_W + 1)'(1);
        last_col = ocol_inc >= (ADDR_W + 1)'(aw_use);
        last_row = orow_inc >= (HCNT_W + 1)'(ah_use);
        last     = has_out && last_col && last_row;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // next state and output valid
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (take) state_next = S_SHIFT;
            S_SHIFT: state_next = has_out_reg ? S_SUM : S_IDLE;
            S_SUM:   state_next = S_DIV;
            S_DIV:   if (dp_status.div_done) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // datapath commands
    always_comb
    begin
        dp_cmd           = '0;
        dp_cmd.rd_en     = take;
        dp_cmd.pix_load  = take;
        dp_cmd.flush     = flush;
        dp_cmd.shift_en  = state_reg == S_SHIFT;
        dp_cmd.sum_start = state_reg == S_SUM;
        dp_cmd.out_load  = out_load;
        dp_cmd.up        = up_reg;
        dp_cmd.down      = down_reg;
        dp_cmd.left      = left_reg;
        dp_cmd.right     = right_reg;
    end

    assign dp_addr   = col_reg;
    assign out_valid = out_valid_reg;
    assign frame_end = frame_end_reg;

    // state, counters and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            aw_reg           <= WCNT_W'(FRAME_WIDTH_RST);
            ah_reg           <= HCNT_W'(FRAME_HEIGHT_RST);
            total_reg        <= '0;
            items_reg        <= '0;
            col_reg          <= '0;
            orow_reg         <= '0;
            ocol_reg         <= '0;
            has_out_reg      <= 1'b0;
            last_reg         <= 1'b0;
            up_reg           <= 1'b0;
            down_reg         <= 1'b0;
            left_reg         <= 1'b0;
            right_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            frame_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= TOT_W'(aw_reg) * TOT_W'(ah_reg);

            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_W_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_H_W-1:0];
                    default: ;
                endcase
            end

            // position bookkeeping for an accepted word
            if (take)
            begin
                if (first)
                begin
                    aw_reg <= width_clamped;
                    ah_reg <= height_clamped;
                end
                has_out_reg <= has_out;
                last_reg    <= last;
                up_reg      <= orow_reg != '0;
                down_reg    <= !last_row;
                left_reg    <= ocol_reg != '0;
                right_reg   <= !last_col && (col_reg != '0);

                if (last)
                begin
                    items_reg <= '0;
                    col_reg   <= '0;
                    orow_reg  <= '0;
                    ocol_reg  <= '0;
                end
                else
                begin
                    items_reg <= items_reg + ITEM_W'(1);
                    if (col_inc >= (ADDR_W + 1)'(aw_use))
                        col_reg <= '0;
                    else
                        col_reg <= col_inc[ADDR_W-1:0];
                    if (has_out)
                    begin
                        if (last_col)
                        begin
                            ocol_reg <= '0;
                            orow_reg <= orow_inc[HCNT_W-1:0];
                        end
                        else
                        begin
                            ocol_reg <= ocol_inc[ADDR_W-1:0];
                        end
                    end
                end
            end

            if (out_load)
                frame_end_reg <= last_reg;
        end
    end

endmodule
`default_nettype wire

FILE: sv/bblur_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bblur_checker
// Port-level checks on the box blur stream, bound to the top level.
// ---------------------------------------------------------------------------
module bblur_checker
    import bblur_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        cmd,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  blurred_red,
    input wire logic [7:0]  blurred_green,
    input wire logic [7:0]  blurred_blue,
    input wire logic        frame_end
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blurred_red)
            && $stable(blurred_green) && $stable(blurred_blue) && $stable(frame_end))
        else $error("result word changed while stalled");

    // a pixel word always starts work, so the input closes behind it
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == CMD_PIXEL |=> !in_ready)
        else $error("input still open after a pixel word");

    // a new result only appears out of a busy phase
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while input was open");

    // no result right behind an accepted word
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

endmodule

bind box_blur_3x3_stream_top bblur_checker u_bblur_checker (.*);
`default_nettype wire
